// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the masked s-box rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check held off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/msbt3_pkg.sv =====
// shared types, constants and the present s-box for the masked s-box block
// no dependencies
package msbt3_pkg;

  localparam int CALL_COUNT  = 496;
  localparam int TABLE_SIZE  = 16;
  localparam int SEED_BITS   = 13;
  localparam int NIB_W       = 4;
  localparam int CALL_W      = 9;
  localparam int POS_W       = 4;
  localparam int ADDR_W      = CALL_W + POS_W;
  localparam int ENTRY_COUNT = CALL_COUNT * TABLE_SIZE;
  localparam int SEED_W      = NIB_W * (SEED_BITS + 1);
  localparam int RTAB_W      = NIB_W * TABLE_SIZE;
  localparam int SHARE_W     = 2 * NIB_W;
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_A = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_B = 2'd2;

  // action codes
  localparam logic ACT_PRECOMP = 1'b0;
  localparam logic ACT_LOOKUP  = 1'b1;

  // mode codes
  localparam logic MODE_STORED = 1'b0;
  localparam logic MODE_GEN    = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SEED_W-1:0] seed_a;
    logic [SEED_W-1:0] seed_b;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [CALL_W-1:0] call_index;
    logic [NIB_W-1:0]  mask_one;
    logic [NIB_W-1:0]  mask_two;
    logic [NIB_W-1:0]  mask_three;
    logic [NIB_W-1:0]  rand_shift;
    logic [NIB_W-1:0]  rand_out_one;
    logic [NIB_W-1:0]  rand_out_two;
    logic [RTAB_W-1:0] rand_table;
    logic [NIB_W-1:0]  masked_in;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] share_zero;
    logic [NIB_W-1:0] share_one;
    logic [NIB_W-1:0] share_two;
    logic [NIB_W-1:0] share_three;
  } res_t;

  function automatic logic [NIB_W-1:0] sbox(input logic [NIB_W-1:0] x);
    logic [NIB_W-1:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

endpackage

// ===== hw/rtl/msbt3_ram.sv =====
// generic simple dual-port ram, one write and one registered read a cycle
// no dependencies
module msbt3_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/msbt3_gen.sv =====
// subset-sum nibble generator over the 13-bit table address
// depends on msbt3_pkg
module msbt3_gen (
  input  logic [msbt3_pkg::SEED_W-1:0] seed,
  input  logic [msbt3_pkg::ADDR_W-1:0] addr,
  output logic [msbt3_pkg::NIB_W-1:0]  value
);

  always_comb begin
    value = seed[msbt3_pkg::NIB_W-1:0];
    // each address bit adds its own seed nibble
    for (int j = 1; j <= msbt3_pkg::SEED_BITS; j++) begin
      if (addr[j-1]) begin
        value = value ^ seed[msbt3_pkg::NIB_W*j +: msbt3_pkg::NIB_W];
      end
    end
  end

endmodule

// ===== hw/rtl/msbt3_seq.sv =====
// sequencer, table stores and shared generator for the masked s-box
// depends on msbt3_pkg, msbt3_ram, msbt3_gen and assert_macros.svh
`include "assert_macros.svh"

module msbt3_seq (
  input  logic              clk,
  input  logic              rst,
  input  msbt3_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  msbt3_pkg::item_t  in_item,
  input  logic              out_free,
  output msbt3_pkg::res_t   res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRE   = 4'b0010,
    ST_LK_RD = 4'b0100,
    ST_LK_GA = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [msbt3_pkg::POS_W-1:0]  cnt;
  logic [msbt3_pkg::CALL_W-1:0] call_r;
  logic [msbt3_pkg::NIB_W-1:0]  d_r, m1_r, v_r, y1_r, y2_r, a_r;
  logic [msbt3_pkg::RTAB_W-1:0] rt_r;
  logic                         oor_r;
  logic [msbt3_pkg::NIB_W-1:0]  gen_b;

  logic                         accept, in_range;
  logic [msbt3_pkg::POS_W-1:0]  pos;
  logic [msbt3_pkg::ADDR_W-1:0] pre_addr, lk_addr, gen_addr;
  logic [msbt3_pkg::SEED_W-1:0] gen_seed;
  logic [msbt3_pkg::NIB_W-1:0]  gen_val, mt_wdata, rt_wdata, mt_rdata, rt_rdata;
  logic [msbt3_pkg::SHARE_W-1:0] ss_rdata;
  logic                         mt_we, rt_we, ss_we;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (in_item.call_index < msbt3_pkg::CALL_W'(msbt3_pkg::CALL_COUNT));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.action == msbt3_pkg::ACT_LOOKUP) begin
            state_next = ST_LK_RD;
          end else if (in_range) begin
            state_next = ST_PRE;
          end
        end
      end
      ST_PRE: begin
        if (cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_LK_RD: state_next = ST_LK_GA;
      ST_LK_GA: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PRE) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      call_r <= in_item.call_index;
      d_r    <= in_item.mask_two ^ in_item.rand_shift ^ in_item.mask_three;
      m1_r   <= in_item.mask_one;
      v_r    <= in_item.rand_shift;
      y1_r   <= in_item.rand_out_one;
      y2_r   <= in_item.rand_out_two;
      rt_r   <= in_item.rand_table;
      a_r    <= in_item.masked_in;
      oor_r  <= !in_range;
    end
    if (state == ST_LK_RD) begin
      gen_b <= gen_val;
    end
  end

  // precompute walks the positions in order, writing the permuted slot
  assign pos      = d_r ^ cnt;
  assign pre_addr = {call_r, pos};
  assign lk_addr  = {call_r, a_r};

  // one generator serves all three uses
  always_comb begin
    gen_seed = cfg.seed_a ^ cfg.seed_b;
    gen_addr = pre_addr;
    if (state == ST_LK_RD) begin
      gen_seed = cfg.seed_b;
      gen_addr = lk_addr;
    end else if (state == ST_LK_GA) begin
      gen_seed = cfg.seed_a;
      gen_addr = lk_addr;
    end
  end

  msbt3_gen u_gen (
    .seed  (gen_seed),
    .addr  (gen_addr),
    .value (gen_val)
  );

  always_comb begin
    mt_wdata = msbt3_pkg::sbox(v_r ^ cnt ^ m1_r) ^ y1_r;
    if (cfg.mode == msbt3_pkg::MODE_STORED) begin
      mt_wdata = mt_wdata ^ rt_r[msbt3_pkg::NIB_W*pos +: msbt3_pkg::NIB_W] ^ y2_r;
    end else begin
      mt_wdata = mt_wdata ^ gen_val;
    end
  end

  assign rt_wdata = rt_r[msbt3_pkg::NIB_W*cnt +: msbt3_pkg::NIB_W];
  assign mt_we    = (state == ST_PRE);
  assign rt_we    = (state == ST_PRE) && (cfg.mode == msbt3_pkg::MODE_STORED);
  assign ss_we    = (state == ST_PRE) && (cnt == '0);

  msbt3_ram #(.DEPTH(msbt3_pkg::ENTRY_COUNT), .WIDTH(msbt3_pkg::NIB_W)) u_mt (
    .clk   (clk),
    .we    (mt_we),
    .waddr (pre_addr),
    .wdata (mt_wdata),
    .raddr (lk_addr),
    .rdata (mt_rdata)
  );

  msbt3_ram #(.DEPTH(msbt3_pkg::ENTRY_COUNT), .WIDTH(msbt3_pkg::NIB_W)) u_rt (
    .clk   (clk),
    .we    (rt_we),
    .waddr ({call_r, cnt}),
    .wdata (rt_wdata),
    .raddr (lk_addr),
    .rdata (rt_rdata)
  );

  msbt3_ram #(.DEPTH(msbt3_pkg::CALL_COUNT), .WIDTH(msbt3_pkg::SHARE_W)) u_ss (
    .clk   (clk),
    .we    (ss_we),
    .waddr (call_r),
    .wdata ({y2_r, y1_r}),
    .raddr (call_r),
    .rdata (ss_rdata)
  );

  always_comb begin
    res.valid       = (state == ST_LK_GA) && out_free;
    res.share_zero  = mt_rdata;
    res.share_one   = ss_rdata[msbt3_pkg::NIB_W-1:0];
    res.share_two   = ss_rdata[msbt3_pkg::SHARE_W-1:msbt3_pkg::NIB_W];
    res.share_three = rt_rdata;
    if (cfg.mode == msbt3_pkg::MODE_GEN) begin
      res.share_two   = gen_b;
      res.share_three = gen_val;
    end
    if (oor_r) begin
      res.share_zero  = '0;
      res.share_one   = '0;
      res.share_two   = '0;
      res.share_three = '0;
    end
  end

  `ASSERT_CLK(a_rst_idle, clk, rst |=> (state == ST_IDLE), "reset did not return to idle")
  `ASSERT_RST(a_pre_len, clk, rst,
    $rose(state == ST_PRE) |-> ##15 (state == ST_PRE) ##1 (state == ST_IDLE),
    "precompute did not take sixteen cycles")
  `ASSERT_RST(a_cnt_pre, clk, rst, (cnt != '0) |-> (state == ST_PRE),
    "position counter running outside precompute")
  `ASSERT_RST(a_we_pre, clk, rst, (mt_we || rt_we || ss_we) |-> (state == ST_PRE),
    "store written outside precompute")
  `ASSERT_RST(a_lk_order, clk, rst,
    (state == ST_LK_GA) |-> $past((state == ST_LK_RD) || (state == ST_LK_GA)),
    "lookup result stage entered without a read")

endmodule

// ===== hw/rtl/masked_sbox_table_third_order.sv =====
// top level of the third-order masked present s-box with per-call tables
// depends on msbt3_pkg and msbt3_seq
//
// A precompute transfer (tuser low) builds the sixteen masked table entries of one s-box
// call and stores its output shares; a lookup transfer (tuser high) returns four output
// shares whose xor is S(x) for the masked input. Items are handled one at a time by a
// small sequencer around one shared subset-sum generator and three single-port-write
// stores. During a precompute one table entry is written per cycle, sixteen in all, since
// the masked table has one write port, and no new item is accepted until it ends. A
// precompute with an index of 496 or more is dropped at once. A lookup goes through
// accept, a registered store read with the second generator value, then the first
// generator value and the result; it waits in the result step only while the output
// register is still full and not taken. Configuration writes take effect at once and
// belong in idle periods. The stores are not cleared by reset, so there is no clearing
// pass; looking up a call that was never precomputed gives unspecified shares.
module masked_sbox_table_third_order (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [msbt3_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [msbt3_pkg::SEED_W-1:0]         cfg_wdata,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // call_index, mask_one, mask_two, mask_three, rand_shift, rand_out_one,
  // rand_out_two, rand_table, masked_in, zero pad
  input  logic [msbt3_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic                                 s_axis_tuser,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // share_zero, share_one, share_two, share_three
  output logic [msbt3_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  msbt3_pkg::cfg_t  cfg;
  msbt3_pkg::item_t item;
  msbt3_pkg::res_t  res;
  logic             out_free;
  logic [msbt3_pkg::OUT_DATA_W-1:0] out_data;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= msbt3_pkg::MODE_STORED;
      cfg.seed_a <= '0;
      cfg.seed_b <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        msbt3_pkg::REG_MODE:   cfg.mode   <= cfg_wdata[0];
        msbt3_pkg::REG_SEED_A: cfg.seed_a <= cfg_wdata;
        msbt3_pkg::REG_SEED_B: cfg.seed_b <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the input transfer, lowest field first
  assign item.action       = s_axis_tuser;
  assign item.call_index   = s_axis_tdata[8:0];
  assign item.mask_one     = s_axis_tdata[12:9];
  assign item.mask_two     = s_axis_tdata[16:13];
  assign item.mask_three   = s_axis_tdata[20:17];
  assign item.rand_shift   = s_axis_tdata[24:21];
  assign item.rand_out_one = s_axis_tdata[28:25];
  assign item.rand_out_two = s_axis_tdata[32:29];
  assign item.rand_table   = s_axis_tdata[96:33];
  assign item.masked_in    = s_axis_tdata[100:97];

  // output register frees in the same cycle its transfer completes
  assign out_free = !m_axis_tvalid || m_axis_tready;

  msbt3_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (item),
    .out_free (out_free),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= {res.share_three, res.share_two, res.share_one, res.share_zero};
    end
  end

  assign m_axis_tdata = out_data;

endmodule

// ===== test/masked_sbox_table_third_order_tb.sv =====
// self-checking testbench for the third-order masked present s-box table block
// depends on msbt3_pkg and masked_sbox_table_third_order; drives both streams and
// the config port, predicts every lookup's four shares and compares them on arrival
module masked_sbox_table_third_order_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msbt3_pkg::*;

  // present s-box, nibble i holds S(i)
  localparam logic [63:0] PRESENT_NIBBLES = 64'h2174_8FE3_DA09_B65C;
  localparam int          SETTLE_CYCLES   = 24;   // precompute busy time plus margin
  localparam int          MAX_CALL_CODE   = 511;  // largest value the index field holds

  typedef struct packed {
    logic [NIB_W-1:0] s0;
    logic [NIB_W-1:0] s1;
    logic [NIB_W-1:0] s2;
    logic [NIB_W-1:0] s3;
  } share_set_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SEED_W-1:0]     cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  masked_sbox_table_third_order i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // shadow of the config registers, as the block holds them
  logic              cur_mode   = MODE_STORED;
  logic [SEED_W-1:0] cur_seed_a = '0;
  logic [SEED_W-1:0] cur_seed_b = '0;

  // shadow of the three stores
  logic [NIB_W-1:0] masked_tbl [ENTRY_COUNT];
  logic [NIB_W-1:0] rand_tbl   [ENTRY_COUNT];
  logic [NIB_W-1:0] out_one_st [CALL_COUNT];
  logic [NIB_W-1:0] out_two_st [CALL_COUNT];

  // which calls can be read back without touching unwritten entries
  bit built_flag  [CALL_COUNT];
  bit stored_flag [CALL_COUNT];
  int built_calls[$];
  int stored_calls[$];

  share_set_t expected_shares[$];
  int         fail_count    = 0;
  int         items_sent    = 0;
  int         src_idle_pct  = 0;
  int         sink_idle_pct = 0;
  int         hold_request  = 0;
  int         hold_left     = 0;

  // subset-sum generator: base nibble, then one nibble per set address bit
  function automatic logic [NIB_W-1:0] subset_sum_nibble(input logic [SEED_W-1:0] seed,
                                                         input logic [ADDR_W-1:0] addr);
    logic [NIB_W-1:0] acc;
    acc = seed[NIB_W-1:0];
    for (int j = 1; j <= SEED_BITS; j++) begin
      if (addr[j-1]) acc ^= seed[NIB_W*j +: NIB_W];
    end
    return acc;
  endfunction

  // update the store shadow for a precompute, queue the shares a lookup returns
  task automatic predict_shares(input item_t it);
    logic [NIB_W-1:0]  d;
    logic [NIB_W-1:0]  val;
    logic [ADDR_W-1:0] addr;
    share_set_t        want;
    int                c;
    c = int'(it.call_index);
    if (it.action == ACT_PRECOMP) begin
      // out-of-range precompute is dropped without effect
      if (c < CALL_COUNT) begin
        d = it.mask_two ^ it.rand_shift ^ it.mask_three;
        out_one_st[c] = it.rand_out_one;
        out_two_st[c] = it.rand_out_two;
        if (cur_mode == MODE_STORED) begin
          for (int i = 0; i < TABLE_SIZE; i++)
            rand_tbl[{it.call_index, POS_W'(i)}] = it.rand_table[NIB_W*i +: NIB_W];
          if (!stored_flag[c]) begin
            stored_flag[c] = 1'b1;
            stored_calls.push_back(c);
          end
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
          addr = {it.call_index, d ^ POS_W'(i)};
          val  = PRESENT_NIBBLES[NIB_W*(it.rand_shift ^ POS_W'(i) ^ it.mask_one) +: NIB_W]
                 ^ it.rand_out_one;
          if (cur_mode == MODE_STORED)
            val ^= rand_tbl[addr] ^ it.rand_out_two;
          else
            val ^= subset_sum_nibble(cur_seed_a, addr) ^ subset_sum_nibble(cur_seed_b, addr);
          masked_tbl[addr] = val;
        end
        if (!built_flag[c]) begin
          built_flag[c] = 1'b1;
          built_calls.push_back(c);
        end
      end
    end else begin
      if (c >= CALL_COUNT) begin
        // out-of-range lookup answers with all shares zero
        want = '0;
      end else begin
        addr    = {it.call_index, it.masked_in};
        want.s0 = masked_tbl[addr];
        want.s1 = out_one_st[c];
        if (cur_mode == MODE_STORED) begin
          want.s2 = out_two_st[c];
          want.s3 = rand_tbl[addr];
        end else begin
          want.s2 = subset_sum_nibble(cur_seed_b, addr);
          want.s3 = subset_sum_nibble(cur_seed_a, addr);
        end
      end
      expected_shares.push_back(want);
    end
  endtask

  // offer one item, possibly after a random gap; tvalid stays high afterwards
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {3'b000, it.masked_in, it.rand_table, it.rand_out_two, it.rand_out_one,
                      it.rand_shift, it.mask_three, it.mask_two, it.mask_one, it.call_index};
    do @(posedge clk); while (!s_axis_tready);
    predict_shares(it);
    items_sent++;
  endtask

  // stop offering, wait for every outstanding result and for any precompute to finish
  task automatic drain_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_shares.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_shares.size() != 0) begin
      $error("%0d expected results never arrived", expected_shares.size());
      fail_count++;
      expected_shares.delete();
    end
  endtask

  // all three registers in consecutive cycles; only called while the block is idle
  task automatic set_config(input logic m, input logic [SEED_W-1:0] a,
                            input logic [SEED_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MODE;
    cfg_wdata <= SEED_W'(m);
    @(posedge clk);
    cfg_addr  <= REG_SEED_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_addr  <= REG_SEED_B;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_mode   = m;
    cur_seed_a = a;
    cur_seed_b = b;
  endtask

  function automatic item_t random_item();
    item_t it;
    it.action       = 1'($urandom_range(1));
    it.call_index   = CALL_W'($urandom_range(MAX_CALL_CODE));
    it.mask_one     = NIB_W'($urandom_range(15));
    it.mask_two     = NIB_W'($urandom_range(15));
    it.mask_three   = NIB_W'($urandom_range(15));
    it.rand_shift   = NIB_W'($urandom_range(15));
    it.rand_out_one = NIB_W'($urandom_range(15));
    it.rand_out_two = NIB_W'($urandom_range(15));
    it.rand_table   = {$urandom, $urandom};
    it.masked_in    = NIB_W'($urandom_range(15));
    return it;
  endfunction

  function automatic logic [SEED_W-1:0] random_seed();
    return SEED_W'({$urandom, $urandom});
  endfunction

  // mostly a small pool so tables get rebuilt and reread, with both ends of the range
  function automatic int pick_call();
    if ($urandom_range(1)) return ($urandom_range(16) == 16) ? CALL_COUNT - 1 : $urandom_range(15);
    return $urandom_range(CALL_COUNT - 1);
  endfunction

  // a call whose entries the current mode reads have all been written
  function automatic bit pick_ready_call(output int c);
    if (cur_mode == MODE_STORED) begin
      if (stored_calls.size() == 0) return 1'b0;
      c = stored_calls[$urandom_range(stored_calls.size() - 1)];
    end else begin
      if (built_calls.size() == 0) return 1'b0;
      c = built_calls[$urandom_range(built_calls.size() - 1)];
    end
    return 1'b1;
  endfunction

  task automatic lookup(input int c, input logic [NIB_W-1:0] x);
    item_t it;
    it            = random_item();
    it.action     = ACT_LOOKUP;
    it.call_index = CALL_W'(c);
    it.masked_in  = x;
    send_item(it);
  endtask

  task automatic precompute(input int c);
    item_t it;
    it            = random_item();
    it.action     = ACT_PRECOMP;
    it.call_index = CALL_W'(c);
    send_item(it);
  endtask

  // one well-formed build-then-read sequence, or a bit of noise
  task automatic run_sequence();
    int roll;
    int c;
    roll = $urandom_range(99);
    if (roll < 70) begin
      c = pick_call();
      precompute(c);
      repeat ($urandom_range(1, 4)) lookup(c, NIB_W'($urandom_range(15)));
    end else if (roll < 88 && pick_ready_call(c)) begin
      repeat ($urandom_range(1, 3)) lookup(c, NIB_W'($urandom_range(15)));
    end else if (roll < 94) begin
      // index past the last call, either action
      c = $urandom_range(CALL_COUNT, MAX_CALL_CODE);
      if ($urandom_range(1)) lookup(c, NIB_W'($urandom_range(15)));
      else precompute(c);
    end else begin
      // rebuild with nothing read back
      precompute(pick_call());
    end
  endtask

  // all-zero and all-ones items at the first and last call, stored mode
  task automatic test_table_extremes();
    item_t it;
    set_config(MODE_STORED, '0, '0);
    it = '0;
    send_item(it);
    lookup(0, 4'h0);
    lookup(0, 4'hF);
    it            = '1;
    it.action     = ACT_PRECOMP;
    it.call_index = CALL_W'(CALL_COUNT - 1);
    send_item(it);
    lookup(CALL_COUNT - 1, 4'h0);
    lookup(CALL_COUNT - 1, 4'hF);
  endtask

  // index beyond the last call: precompute ignored, lookup returns zeros
  task automatic test_index_out_of_range();
    item_t it;
    precompute(CALL_COUNT);
    it = '1;
    send_item(it);
    it.action = ACT_PRECOMP;
    send_item(it);
    lookup(CALL_COUNT, 4'h5);
    lookup(MAX_CALL_CODE, 4'hA);
  endtask

  // tables built in one mode read back under the other mode's shares
  task automatic test_mode_change();
    drain_results();
    set_config(MODE_GEN, '1, '1);
    lookup(0, 4'hF);
    lookup(CALL_COUNT - 1, 4'h0);
    precompute(1);
    lookup(1, NIB_W'($urandom_range(15)));
    drain_results();
    set_config(MODE_STORED, '0, '1);
    lookup(0, 4'h7);
  endtask

  // distinct seed nibbles so each address bit shows up on its own
  task automatic test_generator_bits();
    drain_results();
    set_config(MODE_GEN, 56'h1234_5678_9ABC_DE, 56'hED_CBA9_8765_4321);
    precompute(256);
    lookup(256, 4'h1);
    lookup(CALL_COUNT - 1, 4'hF);
    lookup(1, 4'h8);
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct,
                                     input logic m, input logic [SEED_W-1:0] a,
                                     input logic [SEED_W-1:0] b);
    int stop_at;
    drain_results();
    set_config(m, a, b);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = items_sent + count;
    while (items_sent < stop_at) run_sequence();
  endtask

  // receiver holds off for a long stretch while lookups keep coming, filling the block
  task automatic test_backpressure();
    int c;
    drain_results();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_request  = 300;
    repeat (48) begin
      if (pick_ready_call(c)) lookup(c, NIB_W'($urandom_range(15)));
      else precompute(pick_call());
    end
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // result checker against the oldest outstanding prediction
  share_set_t want;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_shares.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_shares.pop_front();
        if (m_axis_tdata[3:0] !== want.s0) begin
          $error("share_zero: expected %h, actual %h", want.s0, m_axis_tdata[3:0]);
          fail_count++;
        end
        if (m_axis_tdata[7:4] !== want.s1) begin
          $error("share_one: expected %h, actual %h", want.s1, m_axis_tdata[7:4]);
          fail_count++;
        end
        if (m_axis_tdata[11:8] !== want.s2) begin
          $error("share_two: expected %h, actual %h", want.s2, m_axis_tdata[11:8]);
          fail_count++;
        end
        if (m_axis_tdata[15:12] !== want.s3) begin
          $error("share_three: expected %h, actual %h", want.s3, m_axis_tdata[15:12]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_table_extremes();
    test_index_out_of_range();
    test_mode_change();
    test_generator_bits();
    // sender rarely idle, receiver mostly stalled
    test_random_traffic(280, 19, 87, MODE_STORED, '0, '0);
    test_random_traffic(280, 19, 87, MODE_GEN, random_seed(), random_seed());
    // the other way round
    test_random_traffic(280, 87, 19, MODE_GEN, '1, '1);
    test_random_traffic(280, 87, 19, MODE_STORED, random_seed(), random_seed());
    // back to back on both sides
    test_random_traffic(280, 0, 0, MODE_GEN, random_seed(), '0);
    test_random_traffic(280, 0, 0, MODE_STORED, '1, random_seed());
    test_backpressure();
    drain_results();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== masked_sbox_table_third_order.f =====
+incdir+hw/rtl
hw/rtl/msbt3_pkg.sv
hw/rtl/msbt3_ram.sv
hw/rtl/msbt3_gen.sv
hw/rtl/msbt3_seq.sv
hw/rtl/masked_sbox_table_third_order.sv
test/masked_sbox_table_third_order_tb.sv
